>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define ASSERT_ON_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Concurrent check that also watches the cycles in and after reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/core/srtf_pkg.sv
// Types and codes shared by the scheduler modules.
`default_nettype none
package srtf_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  // One process table entry as held in the slot memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Control from the sequencer to the selection unit.
  typedef struct packed {
    logic start;
    logic sample;
  } pick_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/srtf_process_scheduler_unit.sv
// Shortest-remaining-time-first scheduler: slot table in RAM, sequencer and result register.
// Load: accept, examine the slots in order up to the first free one (all of them when full),
//   then post the result once the output register is free.
// Tick: accept, scan every slot through the slot RAM read port, decide, finish on completion,
//   then post the result once the output register is free.
// One transaction in flight at a time; a posted result may wait while the next is accepted.
// Reset (synchronous, rst_n low) clears valid bits, the time counter and the output valid, and idles the sequencer.
`default_nettype none
module srtf_process_scheduler_unit
  import srtf_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // proc_id[7:0], arrive_at[23:8], burst_len[39:24]
  input  wire logic [0:0]  in_tuser,   // op[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // now[15:0], run_id[23:16], finished[24],
                                       // turnaround[40:25], waiting[56:41], zero[63:57]
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DECIDE,
    S_FIN,
    S_POST
  } state_t;

  // Sequencer state
  state_t               state_r,    state_nxt;
  logic [CNT_W-1:0]     cnt_r,      cnt_nxt;
  logic                 rd_pend_r,  rd_pend_nxt;
  logic [IDX_W-1:0]     rd_idx_r,   rd_idx_nxt;
  logic [NUM_SLOTS-1:0] valid_r,    valid_nxt;
  logic [15:0]          clock_r,    clock_nxt;

  // Captured transaction
  op_t                  op_r,       op_nxt;
  logic [7:0]           pid_r,      pid_nxt;
  logic [15:0]          arr_r,      arr_nxt;
  logic [15:0]          bl_r,       bl_nxt;

  // Result under construction
  status_t              status_r,   status_nxt;
  logic [7:0]           run_r,      run_nxt;
  logic                 fin_r,      fin_nxt;
  logic [16:0]          tat_r,      tat_nxt;
  logic [15:0]          wait_r,     wait_nxt;

  // Output register
  logic                 out_vld_r,  out_vld_nxt;
  logic [1:0]           out_user_r, out_user_nxt;
  logic [63:0]          out_data_r, out_data_nxt;

  // Slot memory ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               ram_rdata;

  // Selection unit
  pick_ctrl_t           pick_ctrl;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;
  entry_t               pick_best;

  logic                 in_acc;
  logic                 out_free;
  logic [IDX_W-1:0]     cnt_idx;
  logic [15:0]          rem_dec;
  logic [15:0]          tat_sat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign cnt_idx   = cnt_r[IDX_W-1:0];
  assign rem_dec   = pick_best.remaining - 16'd1;
  assign tat_sat   = tat_r[16] ? 16'hFFFF : tat_r[15:0];

  srtf_ram #(
    .WIDTH (EntryW),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srtf_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (pick_ctrl),
    .now      (clock_r),
    .slot_ok  (valid_r[rd_idx_r]),
    .idx      (rd_idx_r),
    .entry    (ram_rdata),
    .found    (pick_found),
    .best_idx (pick_idx),
    .best     (pick_best)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_pend_nxt  = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    valid_nxt    = valid_r;
    clock_nxt    = clock_r;
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    arr_nxt      = arr_r;
    bl_nxt       = bl_r;
    status_nxt   = status_r;
    run_nxt      = run_r;
    fin_nxt      = fin_r;
    tat_nxt      = tat_r;
    wait_nxt     = wait_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_user_nxt = out_user_r;
    out_data_nxt = out_data_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_idx;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = cnt_idx;
    pick_ctrl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt          = op_t'(in_tuser[0]);
          pid_nxt         = in_tdata[7:0];
          arr_nxt         = in_tdata[23:8];
          // A zero burst is held as one unit so the slot is freed eventually.
          bl_nxt          = (in_tdata[39:24] == 16'd0) ? 16'd1 : in_tdata[39:24];
          cnt_nxt         = '0;
          pick_ctrl.start = 1'b1;
          state_nxt       = (op_t'(in_tuser[0]) == OP_TICK) ? S_SCAN : S_LOAD;
        end
      end

      // Walk the valid bits for the lowest free slot.
      S_LOAD: begin
        run_nxt  = 8'd0;
        fin_nxt  = 1'b0;
        tat_nxt  = '0;
        wait_nxt = 16'd0;
        if (!valid_r[cnt_idx]) begin
          ram_we             = 1'b1;
          ram_waddr          = cnt_idx;
          ram_wdata.id       = pid_r;
          ram_wdata.arrival  = arr_r;
          ram_wdata.burst    = bl_r;
          ram_wdata.remaining = bl_r;
          valid_nxt[cnt_idx] = 1'b1;
          status_nxt         = ST_LOADED;
          state_nxt          = S_POST;
        end else if (cnt_r == CNT_W'(NUM_SLOTS - 1)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_POST;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Stream every slot through the selection unit; data arrives in the cycle after its address.
      S_SCAN: begin
        pick_ctrl.sample = rd_pend_r;
        if (cnt_r < CNT_W'(NUM_SLOTS)) begin
          ram_re      = 1'b1;
          ram_raddr   = cnt_idx;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_idx;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        fin_nxt  = 1'b0;
        tat_nxt  = '0;
        wait_nxt = 16'd0;
        if (!pick_found) begin
          status_nxt = ST_IDLE;
          run_nxt    = 8'd0;
          state_nxt  = S_POST;
        end else begin
          status_nxt          = ST_RAN;
          run_nxt             = pick_best.id;
          ram_we              = 1'b1;
          ram_waddr           = pick_idx;
          ram_wdata           = pick_best;
          ram_wdata.remaining = rem_dec;
          if (rem_dec == 16'd0) begin
            // Completion: free the slot, finish time is now plus one.
            valid_nxt[pick_idx] = 1'b0;
            tat_nxt   = {1'b0, clock_r} + 17'd1 - {1'b0, pick_best.arrival};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_POST;
          end
        end
      end

      S_FIN: begin
        fin_nxt   = 1'b1;
        tat_nxt   = {1'b0, tat_sat};
        wait_nxt  = (tat_sat >= pick_best.burst) ? (tat_sat - pick_best.burst) : 16'd0;
        state_nxt = S_POST;
      end

      // Hold the result until the output register is free.
      S_POST: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_user_nxt = status_r;
          out_data_nxt = {7'd0, wait_r, tat_r[15:0], fin_r, run_r, clock_r};
          if (op_r == OP_TICK && clock_r != 16'hFFFF) begin
            clock_nxt = clock_r + 16'd1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      valid_r   <= '0;
      clock_r   <= 16'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      valid_r   <= valid_nxt;
      clock_r   <= clock_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    arr_r      <= arr_nxt;
    bl_r       <= bl_nxt;
    status_r   <= status_nxt;
    run_r      <= run_nxt;
    fin_r      <= fin_nxt;
    tat_r      <= tat_nxt;
    wait_r     <= wait_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/core/srtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/srtf_pick.sv
// Running minimum over the slot stream: least remaining time, ties to the lowest slot.
`default_nettype none
module srtf_pick
  import srtf_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pick_ctrl_t       ctrl,
  input  wire logic [15:0]      now,
  input  wire logic             slot_ok,
  input  wire logic [IDX_W-1:0] idx,
  input  wire entry_t           entry,
  output logic                  found,
  output logic [IDX_W-1:0]      best_idx,
  output entry_t                best
);

  logic             found_r;
  logic             found_nxt;
  logic [IDX_W-1:0] best_idx_r;
  entry_t           best_r;
  logic             take;

  // Strictly less keeps the earlier slot on a tie.
  assign take = ctrl.sample && slot_ok && (entry.arrival <= now) &&
                (entry.remaining != 16'd0) &&
                (!found_r || (entry.remaining < best_r.remaining));

  always_comb begin
    found_nxt = found_r;
    if (ctrl.start) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    if (take) begin
      best_idx_r <= idx;
      best_r     <= entry;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule
`default_nettype wire

>>> rtl/core/srtf_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module srtf_checker
  import srtf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // A stalled result stays offered and unchanged.
  `ASSERT_ON_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_ON_CLK(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  // Only a run carries an id or a completion flag.
  `ASSERT_ON_CLK(a_no_run_fields, clk, rst_n,
    out_tvalid && (out_tuser != ST_RAN) |-> (out_tdata[24:16] == 9'd0))
  // Nothing is offered straight after reset.
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)

endmodule

bind srtf_process_scheduler_unit srtf_checker u_srtf_checker (.*);
`default_nettype wire

>>> tb/srtf_process_scheduler_unit_tb.sv
// Self-checking stream testbench for the SRTF scheduler: directed corners and random traffic.
module srtf_process_scheduler_unit_tb;
  import srtf_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int HOLD_CYCLES    = 400;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int PHASE_ITEMS    = 175;   // random transactions per idling phase

  // Expected content of one result transaction.
  typedef struct {
    status_t   status;
    bit [15:0] now;
    bit [7:0]  run_id;
    bit        finished;
    bit [15:0] turnaround;
    bit [15:0] waiting;
  } sched_outcome_t;

  // Shadow process table plus the queue of outcomes still owed by the block.
  class sched_scoreboard;
    bit        slot_used   [NUM_SLOTS];
    bit [7:0]  slot_pid    [NUM_SLOTS];
    bit [15:0] slot_arrive [NUM_SLOTS];
    bit [15:0] slot_burst  [NUM_SLOTS];
    bit [15:0] slot_left   [NUM_SLOTS];
    bit [15:0] clock_now;
    sched_outcome_t outcomes_due[$];
    int errors, n_loaded, n_full, n_ran, n_idle, n_finished;

    // Apply one accepted input to the shadow table and queue what it must produce.
    function void note_input(op_t op, bit [7:0] pid, bit [15:0] arr, bit [15:0] blen);
      sched_outcome_t o;
      int free_slot;
      int pick;
      bit [16:0] span;
      o.status = ST_IDLE;
      o.now = clock_now;
      o.run_id = 8'd0;
      o.finished = 1'b0;
      o.turnaround = 16'd0;
      o.waiting = 16'd0;
      if (op == OP_LOAD) begin
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          o.status = ST_FULL;
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_pid[free_slot]    = pid;
          slot_arrive[free_slot] = arr;
          slot_burst[free_slot]  = (blen == 16'd0) ? 16'd1 : blen;
          slot_left[free_slot]   = slot_burst[free_slot];
          o.status = ST_LOADED;
        end
      end else begin
        // Least remaining time among arrived processes; strict less-than keeps ties low.
        pick = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_used[i] && slot_arrive[i] <= clock_now && slot_left[i] != 16'd0)
            if (pick < 0 || slot_left[i] < slot_left[pick]) pick = i;
        if (pick >= 0) begin
          o.status = ST_RAN;
          o.run_id = slot_pid[pick];
          slot_left[pick] = slot_left[pick] - 16'd1;
          if (slot_left[pick] == 16'd0) begin
            span = {1'b0, clock_now} + 17'd1 - {1'b0, slot_arrive[pick]};
            o.finished = 1'b1;
            o.turnaround = span[16] ? 16'hFFFF : span[15:0];
            o.waiting = (o.turnaround >= slot_burst[pick]) ?
                        o.turnaround - slot_burst[pick] : 16'd0;
            slot_used[pick] = 1'b0;
          end
        end
        if (clock_now != 16'hFFFF) clock_now = clock_now + 16'd1;
      end
      outcomes_due = {outcomes_due, o};
    endfunction

    function void compare_field(string name, bit [15:0] exp_val, logic [15:0] act_val);
      if (act_val !== exp_val) begin
        errors++;
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_val, act_val);
      end
    endfunction

    // Match one accepted result against the oldest outstanding outcome.
    function void check_result(logic [1:0] st, logic [63:0] d);
      sched_outcome_t e;
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected nothing, actual status %0d data %h",
                 $time, st, d);
        return;
      end
      e = outcomes_due.pop_front();
      compare_field("status", 16'(e.status), 16'(st));
      compare_field("now", e.now, d[15:0]);
      compare_field("run_id", 16'(e.run_id), 16'(d[23:16]));
      compare_field("finished", 16'(e.finished), 16'(d[24]));
      compare_field("turnaround", e.turnaround, d[40:25]);
      compare_field("waiting", e.waiting, d[56:41]);
      compare_field("padding", 16'd0, 16'(d[63:57]));
      case (e.status)
        ST_LOADED: n_loaded++;
        ST_FULL:   n_full++;
        ST_RAN:    n_ran++;
        default:   n_idle++;
      endcase
      if (e.finished) n_finished++;
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [39:0] in_tdata   = '0;   // proc_id[7:0], arrive_at[23:8], burst_len[39:24]
  logic [0:0]  in_tuser   = '0;   // op[0]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [63:0] out_tdata;         // now[15:0], run_id[23:16], finished[24],
                                  // turnaround[40:25], waiting[56:41], zero[63:57]
  logic [1:0]  out_tuser;         // status[1:0]

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int quiet_cycles  = 0;

  sched_scoreboard sb = new();

  srtf_process_scheduler_unit #(.NUM_SLOTS(NUM_SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random ready, except for a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rst_n) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Monitor both channels at the edge; results are checked before the new input is noted,
  // since a result leaving at the same edge always belongs to an earlier transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        sb.note_input(op_t'(in_tuser[0]), in_tdata[7:0], in_tdata[23:8], in_tdata[39:24]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it; return once accepted.
  task automatic send_item(op_t op, bit [7:0] pid, bit [15:0] arr, bit [15:0] blen);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {blen, arr, pid};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly short bursts arriving near the current clock, so processes keep
  // finishing; a few far-future arrivals and full-width bursts cover the high bits.
  task automatic send_random_item();
    bit [16:0] soon;
    bit [15:0] arr;
    bit [15:0] blen;
    int pick_arr;
    int pick_len;
    if ($urandom_range(1)) begin
      send_tick();
    end else begin
      pick_arr = $urandom_range(99);
      pick_len = $urandom_range(99);
      soon = {1'b0, sb.clock_now} + 17'($urandom_range(12));
      if (pick_arr < 3)       arr = 16'($urandom);
      else if (pick_arr < 10) arr = 16'd0;
      else                    arr = soon[16] ? 16'hFFFF : soon[15:0];
      if (pick_len < 8)       blen = 16'd0;
      else if (pick_len < 10) blen = 16'($urandom);
      else if (pick_len < 14) blen = 16'd1;
      else                    blen = 16'($urandom_range(12, 2));
      send_item(OP_LOAD, 8'($urandom), arr, blen);
    end
  endtask

  // Hold until every owed result is back, then let the block settle.
  task automatic drain();
    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one idling: sender seldom, receiver often.
    tx_idle_pct = 14;
    rx_idle_pct = 47;

    // Directed corners: idle tick on an empty table, zero burst promoted to one,
    // a process at the field maxima that arrives only at the last clock value,
    // fill to the full table with ties and future arrivals, then a rejected load.
    send_tick();
    send_item(OP_LOAD, 8'd0, 16'd0, 16'd0);
    send_tick();
    send_item(OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF);
    for (int i = 1; i <= NUM_SLOTS - 1; i++)
      send_item(OP_LOAD, 8'(i), 16'(i % 5), 16'((i % 4) + 1));
    send_item(OP_LOAD, 8'h5A, 16'd0, 16'd1);
    repeat (5) send_tick();

    // Random traffic over three idling phases.
    repeat (PHASE_ITEMS) send_random_item();
    tx_idle_pct = 47;
    rx_idle_pct = 14;
    repeat (PHASE_ITEMS) send_random_item();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Stall the result side while inputs keep coming, so the block backs up.
    hold_requests = hold_requests + 1;
    repeat (PHASE_ITEMS) send_random_item();
    in_tvalid <= 1'b0;
    drain();

    if (sb.outcomes_due.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.outcomes_due.size());
    end
    $display("Checked %0d results: %0d loads, %0d full, %0d runs (%0d completed), %0d idle",
             sb.n_loaded + sb.n_full + sb.n_ran + sb.n_idle, sb.n_loaded, sb.n_full,
             sb.n_ran, sb.n_finished, sb.n_idle);
    $display("Covered corner loads, three idling mixes and a %0d-cycle output stall",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/srtf_pkg.sv
rtl/core/srtf_ram.sv
rtl/core/srtf_pick.sv
rtl/core/srtf_process_scheduler_unit.sv
rtl/core/srtf_checker.sv
tb/srtf_process_scheduler_unit_tb.sv
